>>> hw/rtl/pes_pkg.sv
// Shared types and constants of the periodic event scheduler.
`default_nettype none
package pes_pkg;

  localparam int DUE_W    = 32;
  localparam int ID_W     = 16;
  localparam int PER_W    = 16;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  localparam logic REQ_REGISTER = 1'b0;
  localparam logic REQ_EVENT    = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_DN_RD,
    S_DN_CMP,
    S_UP_RD,
    S_UP_CMP,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_REG,
    OP_FULL,
    OP_EMPTY,
    OP_TAKE,
    OP_DN_RD,
    OP_DN_CMP,
    OP_UP_RD,
    OP_UP_CMP
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic dn_move;
    logic up_move;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/pes_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none
module pes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic      [WIDTH-1:0]                        rdata_a,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic      [WIDTH-1:0]                        rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

>>> hw/rtl/pes_datapath.sv
// Datapath of the scheduler: heap memory, moving entry, entry count and result registers.
`default_nettype none
module pes_datapath import pes_pkg::*; #(
  parameter int MAX_USERS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                cmd,
  output stat_t                    stat,
  input  wire logic [ID_W-1:0]     in_user_id,
  input  wire logic [PER_W-1:0]    in_period,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [ID_W-1:0]          out_event_id,
  output logic [DUE_W-1:0]         out_event_time,
  output logic [STATUS_W-1:0]      out_status
);

  localparam int AW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int CW = $clog2(MAX_USERS + 1);
  localparam int IW = AW + 2;
  localparam int EW = DUE_W + ID_W + PER_W + AW;
  localparam int KW = DUE_W + ID_W + AW;

  function automatic logic [KW-1:0] key_of(input logic [EW-1:0] e);
    key_of = {e[EW-1 -: DUE_W + ID_W], e[AW-1:0]};
  endfunction

  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [DUE_W-1:0]    mov_due_r, mov_due_nxt;
  logic [ID_W-1:0]     mov_id_r, mov_id_nxt;
  logic [PER_W-1:0]    mov_per_r, mov_per_nxt;
  logic [AW-1:0]       mov_slot_r, mov_slot_nxt;
  logic [ID_W-1:0]     res_id_r, res_id_nxt;
  logic [DUE_W-1:0]    res_time_r, res_time_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                out_valid_r;
  logic [ID_W-1:0]     out_id_r;
  logic [DUE_W-1:0]    out_time_r;
  logic [STATUS_W-1:0] out_status_r;

  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [EW-1:0] wdata, rd_a, rd_b, mov_elem, child;
  logic [IW-1:0] left_idx, right_idx, count_ext;
  logic [AW-1:0] parent_idx, pos_m1, child_idx;
  logic          left_ok, right_ok, pick_b;
  logic [KW-1:0] mov_key;
  logic [DUE_W-1:0] rd_due;
  logic [PER_W-1:0] rd_per;
  logic [DUE_W:0]   due_sum;

  pes_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_USERS)
  ) u_heap (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .rdata_a(rd_a),
    .raddr_b(raddr_b),
    .rdata_b(rd_b)
  );

  assign mov_elem  = {mov_due_r, mov_id_r, mov_per_r, mov_slot_r};
  assign mov_key   = key_of(mov_elem);
  assign left_idx  = {1'b0, pos_r, 1'b1};
  assign right_idx = left_idx + IW'(1);
  assign count_ext = IW'(count_r);
  assign left_ok   = left_idx < count_ext;
  assign right_ok  = right_idx < count_ext;
  assign pick_b    = right_ok && (key_of(rd_b) < key_of(rd_a));
  assign child     = pick_b ? rd_b : rd_a;
  assign child_idx = pick_b ? right_idx[AW-1:0] : left_idx[AW-1:0];
  assign pos_m1    = pos_r - AW'(1);
  assign parent_idx = pos_m1 >> 1;
  assign raddr_b   = right_idx[AW-1:0];

  assign rd_due  = rd_a[EW-1 -: DUE_W];
  assign rd_per  = rd_a[AW +: PER_W];
  assign due_sum = {1'b0, rd_due} + (DUE_W + 1)'(rd_per);

  assign stat.full     = count_r >= CW'(MAX_USERS);
  assign stat.empty    = count_r == '0;
  assign stat.at_root  = pos_r == '0;
  assign stat.dn_move  = left_ok && (key_of(child) < mov_key);
  assign stat.up_move  = mov_key < key_of(rd_a);
  assign stat.out_free = !out_valid_r || !out_stall;

  always_comb begin
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    mov_due_nxt    = mov_due_r;
    mov_id_nxt     = mov_id_r;
    mov_per_nxt    = mov_per_r;
    mov_slot_nxt   = mov_slot_r;
    res_id_nxt     = res_id_r;
    res_time_nxt   = res_time_r;
    res_status_nxt = res_status_r;
    we             = 1'b0;
    waddr          = pos_r;
    wdata          = mov_elem;
    raddr_a        = '0;
    case (cmd.op)
      OP_REG: begin
        mov_due_nxt    = DUE_W'(in_period);
        mov_id_nxt     = in_user_id;
        mov_per_nxt    = in_period;
        mov_slot_nxt   = count_r[AW-1:0];
        pos_nxt        = count_r[AW-1:0];
        count_nxt      = count_r + CW'(1);
        res_id_nxt     = '0;
        res_time_nxt   = '0;
        res_status_nxt = STATUS_OK;
      end
      OP_FULL: begin
        res_id_nxt     = '0;
        res_time_nxt   = '0;
        res_status_nxt = STATUS_FULL;
      end
      OP_EMPTY: begin
        res_id_nxt     = '0;
        res_time_nxt   = '0;
        res_status_nxt = STATUS_EMPTY;
      end
      OP_TAKE: begin
        res_id_nxt     = rd_a[AW + PER_W +: ID_W];
        res_time_nxt   = rd_due;
        res_status_nxt = STATUS_OK;
        mov_due_nxt    = due_sum[DUE_W] ? '1 : due_sum[DUE_W-1:0];
        mov_id_nxt     = rd_a[AW + PER_W +: ID_W];
        mov_per_nxt    = rd_per;
        mov_slot_nxt   = rd_a[AW-1:0];
        pos_nxt        = '0;
      end
      OP_DN_RD: begin
        raddr_a = left_idx[AW-1:0];
      end
      OP_DN_CMP: begin
        we = 1'b1;
        if (stat.dn_move) begin
          wdata   = child;
          pos_nxt = child_idx;
        end
      end
      OP_UP_RD: begin
        raddr_a = parent_idx;
        we      = stat.at_root;
      end
      OP_UP_CMP: begin
        we = 1'b1;
        if (stat.up_move) begin
          wdata   = rd_a;
          pos_nxt = parent_idx;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    mov_due_r    <= mov_due_nxt;
    mov_id_r     <= mov_id_nxt;
    mov_per_r    <= mov_per_nxt;
    mov_slot_r   <= mov_slot_nxt;
    res_id_r     <= res_id_nxt;
    res_time_r   <= res_time_nxt;
    res_status_r <= res_status_nxt;
    if (cmd.load_out) begin
      out_id_r     <= res_id_r;
      out_time_r   <= res_time_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_id   = out_id_r;
  assign out_event_time = out_time_r;
  assign out_status     = out_status_r;

endmodule
`default_nettype wire

>>> hw/rtl/pes_ctrl.sv
// Controller state machine that sequences heap insertion and root update.
`default_nettype none
module pes_ctrl import pes_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire logic  in_req_type,
  output logic       in_stall,
  output cmd_t       cmd,
  input  wire stat_t stat
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NOP;
    cmd.load_out = 1'b0;
    in_stall     = state_r != S_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_REGISTER) begin
            if (stat.full) begin
              cmd.op    = OP_FULL;
              state_nxt = S_DONE;
            end else begin
              cmd.op    = OP_REG;
              state_nxt = S_UP_RD;
            end
          end else if (stat.empty) begin
            cmd.op    = OP_EMPTY;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_TAKE;
          end
        end
      end
      S_TAKE: begin
        cmd.op    = OP_TAKE;
        state_nxt = S_DN_RD;
      end
      S_DN_RD: begin
        cmd.op    = OP_DN_RD;
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.op    = OP_DN_CMP;
        state_nxt = stat.dn_move ? S_DN_RD : S_DONE;
      end
      S_UP_RD: begin
        cmd.op    = OP_UP_RD;
        state_nxt = stat.at_root ? S_DONE : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd.op    = OP_UP_CMP;
        state_nxt = stat.up_move ? S_UP_RD : S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/periodic_event_scheduler.sv
// Top level of the periodic event scheduler: controller and heap datapath.
//
// The input channel takes a register transaction (in_req_type 0, with in_user_id and
// in_period) or an event transaction (in_req_type 1). Each input transaction yields
// exactly one output transaction with out_event_id, out_event_time and out_status.
// Users are kept in a binary min-heap in a two-read-port RAM, ordered by due time,
// then id, then registration order. A register sifts the new entry up; an event
// reports the root, advances its due time by its period (saturating) and sifts it
// down. Each heap level takes a RAM read, then a compare and write back. A rejected
// request (table full or table empty) skips the heap walk. The result becomes valid in
// the same cycle that the next input can be accepted. in_stall is high while a
// transaction is in work. The result sits in an output register, so the next input
// transaction is accepted while an earlier result still waits; a stalled output holds
// its payload, and the following result waits inside the block until the output
// register frees. Reset empties the table and drops any pending output; no RAM
// clearing pass is needed.
`default_nettype none
module periodic_event_scheduler import pes_pkg::*; #(
  parameter int MAX_USERS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_req_type,
  input  wire logic [ID_W-1:0]     in_user_id,
  input  wire logic [PER_W-1:0]    in_period,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [ID_W-1:0]          out_event_id,
  output logic [DUE_W-1:0]         out_event_time,
  output logic [STATUS_W-1:0]      out_status
);

  cmd_t  cmd;
  stat_t stat;

  pes_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_req_type(in_req_type),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .stat       (stat)
  );

  pes_datapath #(
    .MAX_USERS(MAX_USERS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_user_id    (in_user_id),
    .in_period     (in_period),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_id  (out_event_id),
    .out_event_time(out_event_time),
    .out_status    (out_status)
  );

endmodule
`default_nettype wire

>>> hw/rtl/pes_checker.sv
// Port-level checker of the periodic event scheduler and its bind statement.
`default_nettype none
module pes_checker import pes_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [ID_W-1:0]     out_event_id,
  input wire logic [DUE_W-1:0]    out_event_time,
  input wire logic [STATUS_W-1:0] out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_id) &&
      $stable(out_event_time) && $stable(out_status))
    else $error("Stalled output transaction changed.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Input accepted again right after a transaction.");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_error_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_FULL || out_status == STATUS_EMPTY) |->
      out_event_id == '0 && out_event_time == '0)
    else $error("Rejected request carries a nonzero event.");

endmodule

bind periodic_event_scheduler pes_checker u_pes_checker (.*);
`default_nettype wire
